// ===== design/plb_pkg.sv =====
// shared types and constants of the per-source penalty limiter
package plb_pkg;

	// opcodes carried on the input stream's tuser
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BAN_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_CAP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP    = 2'd2;

	localparam logic [7:0] BAN_THRESHOLD_RST = 8'd50;
	localparam logic [7:0] PENALTY_CAP_RST   = 8'd60;
	localparam logic [7:0] DECAY_STEP_RST    = 8'd5;

	// stream widths
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 24;
	localparam int USED_W    = 7;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef struct packed {
		logic        opcode;
		logic [31:0] source_ip;
		logic [7:0]  penalty_amount;
	} cmd_t;

	typedef struct packed {
		logic [7:0] ban_threshold;
		logic [7:0] penalty_cap;
		logic [7:0] decay_step;
	} cfg_t;

	// one table entry as stored in the memory
	typedef struct packed {
		logic        valid;
		logic [7:0]  penalty;
		logic [31:0] key;
	} ent_t;

	typedef struct packed {
		logic       allowed;
		logic [7:0] penalty_now;
		logic       table_full;
	} res_t;

	// back-end status seen by the front end
	typedef struct packed {
		logic clearing;
		logic take;
	} back_stat_t;

endpackage

// ===== design/plb_front.sv =====
// front end: accepts stream transactions and queues them as commands
module plb_front import plb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic       s_tuser,
	input  back_stat_t stat,
	output logic       cmd_valid,
	output cmd_t       cmd
);

	cmd_t              q_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;
	cmd_t              in_cmd;

	assign s_tready  = (cnt_q != QCNT_W'(QUEUE_DEPTH)) && !stat.clearing;
	assign push      = s_tvalid && s_tready;
	assign pop       = stat.take;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_q[rd_ptr_q];

	// classify: tuser is the opcode, tdata holds address then amount
	assign in_cmd.opcode         = s_tuser;
	assign in_cmd.source_ip      = s_tdata[31:0];
	assign in_cmd.penalty_amount = s_tdata[39:32];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== design/plb_back.sv =====
// back end: table memory, scan sequencer and output register
module plb_back import plb_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output back_stat_t stat,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_DONE  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t             state_q;
	ent_t               mem_q [TABLE_ENTRIES];
	ent_t               rdata_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               rd_v_s1;
	logic [IDX_W-1:0]   clr_idx_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic               issuing_q;
	cmd_t               cur_q;
	logic               hit_found_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [7:0]         hit_pen_q;
	logic               free_found_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic [CNT_W-1:0]   count_q;
	res_t               res_q;
	logic               m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	ent_t               mem_wdata;
	logic               mem_re;
	logic               last_s1;
	logic               is_tick;
	logic               hit_now;
	logic               free_now;
	logic               retire_now;
	logic               track;
	logic [7:0]         base_pen;
	logic [8:0]         sum;
	logic [7:0]         new_pen;
	logic               out_free;

	assign is_tick    = (cur_q.opcode == OP_TICK);
	assign last_s1    = rd_v_s1 && (idx_s1 == LAST_IDX);
	assign mem_re     = (state_q == ST_SCAN) && issuing_q;
	assign hit_now    = (state_q == ST_SCAN) && !is_tick && rd_v_s1 && rdata_s1.valid
		&& (rdata_s1.key == cur_q.source_ip);
	assign free_now   = (state_q == ST_SCAN) && !is_tick && rd_v_s1 && !rdata_s1.valid;
	assign retire_now = (state_q == ST_SCAN) && is_tick && rd_v_s1 && rdata_s1.valid
		&& (rdata_s1.penalty <= cfg.decay_step);
	assign track      = hit_found_q || free_found_q;
	assign base_pen   = hit_found_q ? hit_pen_q : 8'd0;
	assign sum        = {1'b0, base_pen} + {1'b0, cur_q.penalty_amount};
	assign new_pen    = (sum > {1'b0, cfg.penalty_cap}) ? cfg.penalty_cap : sum[7:0];
	assign out_free   = !m_tvalid_q || m_tready;

	assign stat.clearing = (state_q == ST_CLEAR);
	assign stat.take     = (state_q == ST_IDLE) && cmd_valid;
	assign m_tvalid      = m_tvalid_q;
	assign m_tdata       = m_tdata_q;

	// single write port: clearing pass, decay rewrite or request update
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_idx_q;
			end
			ST_SCAN: begin
				if (is_tick && rd_v_s1 && rdata_s1.valid) begin
					mem_we            = 1'b1;
					mem_wdata.key     = rdata_s1.key;
					mem_wdata.valid   = !retire_now;
					mem_wdata.penalty = rdata_s1.penalty - cfg.decay_step;
				end
			end
			ST_DONE: begin
				if (!is_tick && track) begin
					mem_we            = 1'b1;
					mem_waddr         = hit_found_q ? hit_idx_q : free_idx_q;
					mem_wdata.valid   = 1'b1;
					mem_wdata.penalty = new_pen;
					mem_wdata.key     = cur_q.source_ip;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem_q[rd_idx_q];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (stat.take) begin
			cur_q <= cmd;
		end
		if (hit_now && !hit_found_q) begin
			hit_idx_q <= idx_s1;
			hit_pen_q <= rdata_s1.penalty;
		end
		if (free_now && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
		if (state_q == ST_DONE) begin
			if (is_tick) begin
				res_q <= '{allowed: 1'b0, penalty_now: 8'd0, table_full: 1'b0};
			end else if (track) begin
				res_q <= '{allowed: (new_pen < cfg.ban_threshold), penalty_now: new_pen,
					table_full: 1'b0};
			end else begin
				res_q <= '{allowed: 1'b1, penalty_now: 8'd0, table_full: 1'b1};
			end
		end
		if ((state_q == ST_EMIT) && out_free) begin
			m_tdata_q <= {7'd0, USED_W'(count_q), res_q.table_full, res_q.penalty_now,
				res_q.allowed};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_idx_q    <= '0;
			rd_idx_q     <= '0;
			issuing_q    <= 1'b0;
			rd_v_s1      <= 1'b0;
			idx_s1       <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			count_q      <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			// drop valid once taken, unless a new result loads in the same cycle
			if (m_tvalid_q && m_tready && !((state_q == ST_EMIT) && out_free)) begin
				m_tvalid_q <= 1'b0;
			end
			rd_v_s1 <= mem_re;
			if (mem_re) begin
				idx_s1 <= rd_idx_q;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
					if (clr_idx_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						rd_idx_q     <= '0;
						issuing_q    <= 1'b1;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issuing_q) begin
						if (rd_idx_q == LAST_IDX) begin
							issuing_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + IDX_W'(1);
						end
					end
					if (hit_now) begin
						hit_found_q <= 1'b1;
					end
					if (free_now) begin
						free_found_q <= 1'b1;
					end
					if (retire_now) begin
						count_q <= count_q - CNT_W'(1);
					end
					if (last_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!is_tick && !hit_found_q && free_found_q) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/per_source_penalty_limiter.sv =====
// top level of the per-source penalty limiter: config registers, front and back
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   s_tdata: source_ip, penalty_amount; s_tuser: opcode
// m_*       out  m_tvalid/m_tready   m_tdata: allowed, penalty_now, table_full, entries_used
// cfg_*     in   cfg_we              cfg_index, cfg_data (no read-back)
//
// each request or decay tick is handled in the back end by a scan through the table
// memory, one entry per cycle on its single read port
// a two-deep command queue takes new transactions while the back end scans
// after reset a clearing pass wipes every table entry; s_tready stays low
// a stalled m_tready holds the result register and the back end waits before its next result
module per_source_penalty_limiter import plb_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] source_ip, [39:32] penalty_amount
	input  logic                 s_tuser,   // [0] opcode
	// output stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // [0] allowed, [8:1] penalty_now,
	                                        // [9] table_full, [16:10] entries_used, rest zero
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	cfg_t       cfg_q;
	back_stat_t stat;
	logic       cmd_valid;
	cmd_t       cmd;

	// config registers; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ban_threshold <= BAN_THRESHOLD_RST;
			cfg_q.penalty_cap   <= PENALTY_CAP_RST;
			cfg_q.decay_step    <= DECAY_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BAN_THRESHOLD: cfg_q.ban_threshold <= cfg_data;
				CFG_PENALTY_CAP:   cfg_q.penalty_cap   <= cfg_data;
				CFG_DECAY_STEP:    cfg_q.decay_step    <= cfg_data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// front end: takes transactions into the command queue
	plb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.stat      (stat),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	// back end: table lookup, decay sweep and result register
	plb_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

`ifndef ASSERT_OFF
	// nothing enters while the table is being wiped
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !s_tready)
		else $error("input accepted during clearing pass");

	// an untracked source is always let through with no penalty
	a_full_allows: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[9]) |-> (m_tdata[0] && (m_tdata[8:1] == 8'd0)))
		else $error("table-full result not allowed or has penalty");

	// table full is reported only when every entry is in use
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[9]) |-> (m_tdata[16:10] == USED_W'(TABLE_ENTRIES)))
		else $error("table-full result with free entries");

	// back end only takes a command the queue actually holds
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		stat.take |-> (cmd_valid && !stat.clearing))
		else $error("command taken from empty queue");
`endif

endmodule
